### design/gcr_pkg.sv
package gcr_pkg;

	localparam int WINDOW_START = 16;
	localparam int WINDOW_END   = 100;
	localparam int AUX_LEN      = 86;
	localparam int MAIN_LEN     = 256;
	localparam int AUX_AW       = $clog2(AUX_LEN);

	localparam logic [7:0] MARK_P1   = 8'hD5;
	localparam logic [7:0] MARK_P2   = 8'hAA;
	localparam logic [7:0] MARK_ADDR = 8'h96;
	localparam logic [7:0] MARK_DATA = 8'hAD;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_CSUM     = 2'd1;
	localparam logic [1:0] ST_NIBBLE   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ADDR,
		PH_SEEK,
		PH_AUX,
		PH_MAIN,
		PH_CHECK,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] v;
	} dec_t;

	typedef struct packed {
		logic              we;
		logic [AUX_AW-1:0] waddr;
		logic [5:0]        wdata;
		logic              re;
		logic [AUX_AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic       valid;
		logic       is_status;
		logic [5:0] v;
		logic [7:0] idx;
		logic [1:0] sel;
		logic [1:0] status;
	} res_t;

	localparam logic [7:0] GCR_CODES [64] = '{
		8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
		8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
		8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
		8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
		8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
		8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
	};

	// 6-and-2 decode on the low 7 bits; codes are unique so matches OR together
	function automatic dec_t gcr_decode(input logic [7:0] b);
		dec_t       d;
		logic [7:0] key;
		d   = '0;
		key = {1'b1, b[6:0]};
		for (int k = 0; k < 64; k++) begin
			if (GCR_CODES[k] == key) begin
				d.ok = 1'b1;
				d.v  = d.v | 6'(k);
			end
		end
		return d;
	endfunction

endpackage

### design/gcr_ctrl.sv
module gcr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [3:0]       cfg_wr_data,
	input  logic             accept,
	input  logic [7:0]       disk_byte,
	input  logic             track_end,
	output gcr_pkg::mem_req_t mem_req,
	output gcr_pkg::res_t    res
);
	import gcr_pkg::*;

	phase_t            phase_q, phase_d;
	logic [3:0]        target_q;
	logic [15:0]       hist_q, hist_d;
	logic [8:0]        cnt_q, cnt_d, cnt_inc;
	logic [7:0]        odd_q, odd_d;
	logic [5:0]        xor_q, xor_d;
	logic              done_q, done_d;
	logic [AUX_AW-1:0] ptr_q, ptr_d;
	logic [1:0]        sel_q, sel_d;
	logic              mark_addr, mark_data, in_window;
	logic [7:0]        sec;
	dec_t              dec;

	assign dec       = gcr_decode(disk_byte);
	assign cnt_inc   = cnt_q + 9'd1;
	assign mark_addr = (hist_q == {MARK_P1, MARK_P2}) && (disk_byte == MARK_ADDR);
	assign mark_data = (hist_q == {MARK_P1, MARK_P2}) && (disk_byte == MARK_DATA);
	assign in_window = (cnt_inc >= 9'(WINDOW_START + 2)) && (cnt_inc < 9'(WINDOW_END + 2));
	assign sec       = {odd_q[6:0], 1'b1} & disk_byte;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: if (mark_addr) phase_d = PH_ADDR;
			PH_ADDR: begin
				if (cnt_inc >= 9'd8)
					phase_d = (sec == {4'd0, target_q}) ? PH_SEEK : PH_HUNT;
			end
			PH_SEEK: begin
				if (mark_data && in_window)
					phase_d = PH_AUX;
				else if (cnt_inc >= 9'(WINDOW_END + 1))
					phase_d = PH_HUNT;
			end
			PH_AUX: begin
				if (!dec.ok)
					phase_d = PH_HUNT;
				else if (cnt_inc >= 9'(AUX_LEN))
					phase_d = PH_MAIN;
			end
			PH_MAIN: begin
				if (!dec.ok)
					phase_d = PH_HUNT;
				else if (cnt_inc >= 9'(MAIN_LEN))
					phase_d = PH_CHECK;
			end
			PH_CHECK: phase_d = (dec.ok && dec.v == xor_q) ? PH_DONE : PH_HUNT;
			PH_DONE:  phase_d = PH_DONE;
			default:  phase_d = PH_HUNT;
		endcase
		if (track_end) phase_d = PH_HUNT;
	end

	always_comb begin
		cnt_d  = cnt_q;
		odd_d  = odd_q;
		xor_d  = xor_q;
		done_d = done_q;
		ptr_d  = ptr_q;
		sel_d  = sel_q;
		hist_d = {hist_q[7:0], disk_byte};
		mem_req.we    = 1'b0;
		mem_req.waddr = cnt_q[AUX_AW-1:0];
		mem_req.wdata = dec.v;
		mem_req.re    = accept;
		mem_req.raddr = ptr_q;
		res = '0;
		unique case (phase_q)
			PH_HUNT: if (mark_addr) cnt_d = 9'd2;
			PH_ADDR: begin
				cnt_d = cnt_inc;
				if (cnt_inc == 9'd7) odd_d = disk_byte;
			end
			PH_SEEK: begin
				cnt_d = cnt_inc;
				if (mark_data && in_window) begin
					cnt_d = '0;
					xor_d = '0;
				end
			end
			PH_AUX: begin
				if (!dec.ok) begin
					res.valid     = 1'b1;
					res.is_status = 1'b1;
					res.status    = ST_NIBBLE;
				end else begin
					mem_req.we = accept;
					xor_d      = xor_q ^ dec.v;
					cnt_d      = cnt_inc;
					if (cnt_inc >= 9'(AUX_LEN)) begin
						cnt_d = '0;
						ptr_d = '0;
						sel_d = '0;
					end
				end
			end
			PH_MAIN: begin
				if (!dec.ok) begin
					res.valid     = 1'b1;
					res.is_status = 1'b1;
					res.status    = ST_NIBBLE;
				end else begin
					xor_d     = xor_q ^ dec.v;
					res.valid = 1'b1;
					res.v     = dec.v;
					res.idx   = cnt_q[7:0];
					res.sel   = sel_q;
					cnt_d     = cnt_inc;
					if (ptr_q == AUX_AW'(AUX_LEN - 1)) begin
						ptr_d = '0;
						sel_d = sel_q + 2'd1;
					end else begin
						ptr_d = ptr_q + AUX_AW'(1);
					end
				end
			end
			PH_CHECK: begin
				res.valid     = 1'b1;
				res.is_status = 1'b1;
				if (!dec.ok)
					res.status = ST_NIBBLE;
				else if (dec.v == xor_q) begin
					res.status = ST_GOOD;
					done_d     = 1'b1;
				end else
					res.status = ST_CSUM;
			end
			PH_DONE: ;
			default: ;
		endcase
		if (track_end) begin
			if (!done_d) begin
				res           = '0;
				res.valid     = 1'b1;
				res.is_status = 1'b1;
				res.status    = ST_NOTFOUND;
			end
			cnt_d  = '0;
			odd_d  = '0;
			xor_d  = '0;
			done_d = 1'b0;
			hist_d = '0;
			ptr_d  = '0;
			sel_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hist_q  <= '0;
			cnt_q   <= '0;
			odd_q   <= '0;
			xor_q   <= '0;
			done_q  <= 1'b0;
			ptr_q   <= '0;
			sel_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hist_q  <= hist_d;
			cnt_q   <= cnt_d;
			odd_q   <= odd_d;
			xor_q   <= xor_d;
			done_q  <= done_d;
			ptr_q   <= ptr_d;
			sel_q   <= sel_d;
		end
	end

`ifndef ASSERT_OFF
	a_aux_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AUX |-> cnt_q < 9'(AUX_LEN))
		else $error("aux count out of range");
	a_main_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MAIN |-> ptr_q < AUX_AW'(AUX_LEN) && sel_q != 2'd3)
		else $error("aux pointer out of range in main field");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && track_end |=> phase_q == PH_HUNT && !done_q && cnt_q == '0)
		else $error("track end did not rearm");
`endif

endmodule

### design/gcr_emit.sv
module gcr_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  gcr_pkg::mem_req_t mem_req,
	input  gcr_pkg::res_t     res,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_is_status,
	output logic [7:0]        out_byte,
	output logic [7:0]        out_index,
	output logic [1:0]        out_status
);
	import gcr_pkg::*;

	// aux nibbles are always written in cycles before the main field reads them
	logic [5:0] aux_mem [AUX_LEN];
	logic [5:0] rdata_q;
	logic       s1_valid_q;
	res_t       res_s1;
	logic       out_valid_q;
	logic       out_free, s1_adv;
	logic [1:0] low;

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_ready = !s1_valid_q || out_free;

	always_ff @(posedge clk) begin
		if (mem_req.we) aux_mem[mem_req.waddr] <= mem_req.wdata;
		if (mem_req.re) rdata_q <= aux_mem[mem_req.raddr];
	end

	always_comb begin
		case (res_s1.sel)
			2'd0:    low = rdata_q[1:0];
			2'd1:    low = rdata_q[3:2];
			default: low = rdata_q[5:4];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) res_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_is_status <= res_s1.is_status;
			out_byte      <= res_s1.is_status ? 8'd0 : {res_s1.v, low};
			out_index     <= res_s1.idx;
			out_status    <= res_s1.status;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("pending result lost");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_is_status |-> out_byte == 8'd0 && out_index == 8'd0)
		else $error("status result carries data");
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_is_status |-> out_status == ST_GOOD)
		else $error("data result carries status");
`endif

endmodule

### design/gcr_sector_reader_core.sv
// Channel   Dir  Fields
// s_axis    in   tdata[7:0] disk_byte, tlast track_end
// m_axis    out  tdata[7:0] data_byte, [15:8] byte_index, [17:16] sector_status;
//                tuser is_status
// cfg       in   cfg_wr_data target_sector, written when cfg_wr_en
//
// One disk byte per cycle while s_axis is not stalled; a result reaches m_axis through
// the result stage (with the aux memory read) and then the output register.
// The aux nibble memory read is registered; its read is issued with the byte.
// Reset clears the control state only; the aux memory needs no clearing pass.
// A stalled m_axis holds one result in the output register and one behind it;
// s_axis stalls only when both are full.
module gcr_sector_reader_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] disk_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] data_byte, [15:8] byte_index, [17:16] sector_status
	output logic        m_axis_tuser   // is_status
);
	import gcr_pkg::*;

	logic       accept;
	mem_req_t   mem_req;
	res_t       res;
	logic [7:0] data_byte, byte_index;
	logic [1:0] sector_status;

	assign accept = s_axis_tvalid && s_axis_tready;

	gcr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.disk_byte   (s_axis_tdata),
		.track_end   (s_axis_tlast),
		.mem_req     (mem_req),
		.res         (res)
	);

	gcr_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mem_req       (mem_req),
		.res           (res),
		.in_ready      (s_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_is_status (m_axis_tuser),
		.out_byte      (data_byte),
		.out_index     (byte_index),
		.out_status    (sector_status)
	);

	assign m_axis_tdata = {6'd0, sector_status, byte_index, data_byte};

endmodule

### tb/tb_gcr_sector_reader_core.sv
module tb_gcr_sector_reader_core;
	timeunit 1ns;
	timeprecision 1ps;

	import gcr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 180;
	localparam int HOLD_CYCLES = 150;

	localparam logic [7:0] DISK_CODES [64] = '{
		8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
		8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
		8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
		8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
		8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
		8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
	};

	typedef struct packed {
		logic       is_status;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [1:0] sector_status;
	} sector_out_t;

	typedef enum {FLAW_NONE, FLAW_CSUM, FLAW_NIBBLE, FLAW_NODATA} flaw_t;

	class sector_decode_tracker;
		logic [3:0]  target;
		phase_t      stage;
		logic [15:0] history;
		int unsigned field_pos;
		logic [7:0]  odd_hold;
		logic [5:0]  aux[AUX_LEN];
		logic [5:0]  xsum;
		bit          done;
		bit          nib_ok[128];
		logic [5:0]  nib_val[128];
		sector_out_t results_due[$];
		int          errors;

		function new();
			foreach (nib_ok[i]) begin
				nib_ok[i]  = 1'b0;
				nib_val[i] = '0;
			end
			for (int k = 0; k < 64; k++) begin
				nib_ok[DISK_CODES[k][6:0]]  = 1'b1;
				nib_val[DISK_CODES[k][6:0]] = 6'(k);
			end
			target = '0;
			errors = 0;
			rearm();
		endfunction

		function void rearm();
			stage     = PH_HUNT;
			history   = '0;
			field_pos = 0;
			odd_hold  = '0;
			xsum      = '0;
			done      = 1'b0;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function void take_disk_byte(input logic [7:0] b, input logic end_of_track);
			logic [7:0]  p2, p1, sec;
			logic [5:0]  v;
			bit          ok, emit;
			sector_out_t r;
			int unsigned idx;
			p2   = history[15:8];
			p1   = history[7:0];
			ok   = nib_ok[b[6:0]];
			v    = nib_val[b[6:0]];
			r    = '0;
			emit = 1'b0;
			case (stage)
				PH_HUNT: begin
					if (p2 == MARK_P1 && p1 == MARK_P2 && b == MARK_ADDR) begin
						stage     = PH_ADDR;
						field_pos = 2;
					end
				end
				PH_ADDR: begin
					field_pos++;
					if (field_pos == 7) begin
						odd_hold = b;
					end else if (field_pos >= 8) begin
						sec   = {odd_hold[6:0], 1'b1} & b;
						stage = (sec == {4'h0, target}) ? PH_SEEK : PH_HUNT;
					end
				end
				PH_SEEK: begin
					field_pos++;
					if (p2 == MARK_P1 && p1 == MARK_P2 && b == MARK_DATA &&
					    field_pos >= WINDOW_START + 2 && field_pos < WINDOW_END + 2) begin
						stage     = PH_AUX;
						field_pos = 0;
						xsum      = '0;
					end else if (field_pos >= WINDOW_END + 1) begin
						stage = PH_HUNT;
					end
				end
				PH_AUX: begin
					if (!ok) begin
						emit            = 1'b1;
						r.is_status     = 1'b1;
						r.sector_status = ST_NIBBLE;
						stage           = PH_HUNT;
					end else begin
						aux[field_pos % AUX_LEN] = v;
						xsum = xsum ^ v;
						field_pos++;
						if (field_pos >= AUX_LEN) begin
							stage     = PH_MAIN;
							field_pos = 0;
						end
					end
				end
				PH_MAIN: begin
					if (!ok) begin
						emit            = 1'b1;
						r.is_status     = 1'b1;
						r.sector_status = ST_NIBBLE;
						stage           = PH_HUNT;
					end else begin
						idx          = field_pos % 256;
						emit         = 1'b1;
						r.data_byte  = {v, 2'(aux[idx % AUX_LEN] >> (2 * (idx / AUX_LEN)))};
						r.byte_index = 8'(idx);
						xsum         = xsum ^ v;
						field_pos++;
						if (field_pos >= MAIN_LEN)
							stage = PH_CHECK;
					end
				end
				PH_CHECK: begin
					emit        = 1'b1;
					r.is_status = 1'b1;
					if (!ok) begin
						r.sector_status = ST_NIBBLE;
						stage           = PH_HUNT;
					end else if (v == xsum) begin
						r.sector_status = ST_GOOD;
						done            = 1'b1;
						stage           = PH_DONE;
					end else begin
						r.sector_status = ST_CSUM;
						stage           = PH_HUNT;
					end
				end
				PH_DONE: ;
				default: stage = PH_HUNT;
			endcase
			history = {history[7:0], b};
			if (end_of_track) begin
				if (!done) begin
					emit            = 1'b1;
					r               = '0;
					r.is_status     = 1'b1;
					r.sector_status = ST_NOTFOUND;
				end
				rearm();
			end
			if (emit)
				results_due.push_back(r);
		endfunction

		function void match_output(input logic tuser, input logic [23:0] tdata);
			sector_out_t e;
			if (results_due.size() == 0) begin
				$error("output with no result due: tuser %0d tdata %h", tuser, tdata);
				errors++;
				return;
			end
			e = results_due.pop_front();
			if (tuser !== e.is_status) begin
				$error("is_status: expected %0d, got %0d", e.is_status, tuser);
				errors++;
			end
			if (tdata[7:0] !== e.data_byte) begin
				$error("data_byte: expected %h, got %h", e.data_byte, tdata[7:0]);
				errors++;
			end
			if (tdata[15:8] !== e.byte_index) begin
				$error("byte_index: expected %0d, got %0d", e.byte_index, tdata[15:8]);
				errors++;
			end
			if (tdata[17:16] !== e.sector_status) begin
				$error("sector_status: expected %0d, got %0d", e.sector_status, tdata[17:16]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [3:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	sector_decode_tracker tracker = new();
	logic [7:0] trk[$];
	int  sent = 0;
	int  result_count = 0;
	int  quiet = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;

	gcr_sector_reader_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int idle_len(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] nibble_of(input logic [5:0] v);
		logic [7:0] b;
		b = DISK_CODES[v];
		if ($urandom_range(0, 7) == 0)
			b[7] = 1'b0;
		return b;
	endfunction

	function automatic logic [7:0] bad_nibble();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (tracker.nib_ok[b[6:0]]);
		return b;
	endfunction

	// caller is at a falling edge; returns at a falling edge with tvalid still high
	task automatic send_byte(input logic [7:0] b, input logic end_of_track);
		int gap;
		gap = idle_len(tx_steady);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= end_of_track;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.take_disk_byte(b, end_of_track);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_track();
		foreach (trk[i])
			send_byte(trk[i], i == trk.size() - 1);
	endtask

	// drain all results, then let the pipeline empty of result-less bytes
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() > 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_target(input logic [3:0] t);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= t;
		@(posedge clk);
		tracker.target = t;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_sector(input logic [7:0] sec, input int gap, input flaw_t flaw);
		logic [5:0] v, sum;
		int         bad_at;
		trk.push_back(MARK_P1);
		trk.push_back(MARK_P2);
		trk.push_back(MARK_ADDR);
		repeat (4) trk.push_back(8'($urandom_range(0, 255)));
		trk.push_back((sec >> 1) | 8'hAA);
		trk.push_back(sec | 8'hAA);
		repeat (gap) trk.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'hFF);
		if (flaw == FLAW_NODATA)
			return;
		trk.push_back(MARK_P1);
		trk.push_back(MARK_P2);
		trk.push_back(MARK_DATA);
		sum    = '0;
		bad_at = (flaw == FLAW_NIBBLE) ? $urandom_range(0, AUX_LEN + MAIN_LEN) : -1;
		for (int i = 0; i <= AUX_LEN + MAIN_LEN; i++) begin
			v = 6'($urandom_range(0, 63));
			if (i == AUX_LEN + MAIN_LEN)
				v = (flaw == FLAW_CSUM) ? sum ^ 6'($urandom_range(1, 63)) : sum;
			else
				sum = sum ^ v;
			trk.push_back((i == bad_at) ? bad_nibble() : nibble_of(v));
		end
	endtask

	task automatic run_track();
		int         gap_edges[4] = '{6, 7, 90, 91};
		int         r, gap, cut;
		logic [7:0] sec;
		flaw_t      flaw;
		bit         aimed;
		trk.delete();
		tx_steady = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) == 0)
			settle();
		if ($urandom_range(0, 9) == 0) begin
			// mark fragments and random bytes
			repeat ($urandom_range(20, 60)) begin
				case ($urandom_range(0, 5))
					0: trk.push_back(MARK_P1);
					1: trk.push_back(MARK_P2);
					2: trk.push_back(MARK_ADDR);
					3: trk.push_back(MARK_DATA);
					default: trk.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			repeat ($urandom_range(0, 6)) trk.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(1, 2)) begin
				r = $urandom_range(0, 19);
				if (r < 13)
					sec = {4'h0, tracker.target};
				else if (r < 18)
					sec = 8'($urandom_range(0, 15));
				else
					sec = 8'($urandom_range(16, 255));
				r = $urandom_range(0, 9);
				if (r < 2)
					gap = gap_edges[$urandom_range(0, 3)];
				else if (r < 6)
					gap = $urandom_range(7, 20);
				else if (r < 9)
					gap = $urandom_range(21, 90);
				else
					gap = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(92, 98);
				aimed = (sec == {4'h0, tracker.target}) && gap >= 7 && gap <= 90;
				r = $urandom_range(0, 19);
				if (aimed)
					flaw = (r < 9) ? FLAW_NONE : (r < 13) ? FLAW_CSUM :
					       (r < 18) ? FLAW_NIBBLE : FLAW_NODATA;
				else
					flaw = (r < 14) ? FLAW_NODATA : FLAW_NONE;
				add_sector(sec, gap, flaw);
			end
			repeat ($urandom_range(0, 4)) trk.push_back(8'hFF);
			trk.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 6) == 0) begin
			cut = $urandom_range(1, trk.size());
			while (trk.size() > cut)
				void'(trk.pop_back());
		end
		send_track();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.match_output(m_axis_tuser, m_axis_tdata);
			result_count++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("gcr_sector_reader_core regression: fail");
			$finish;
		end
	end

	// result sink: random backpressure plus two long holds to fill the block
	initial begin
		int gap;
		int holds;
		holds         = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds < 2 && result_count >= 40 + holds * 660) begin
				holds++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = idle_len(rx_steady);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				rx_steady = !rx_steady;
		end
	end

	initial begin
		logic [3:0] tgt;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset target 0: lone track end, then sector 0 at the earliest data mark
		// with a bad first aux nibble
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		trk.delete();
		add_sector(8'h00, 7, FLAW_NODATA);
		trk.push_back(MARK_P1);
		trk.push_back(MARK_P2);
		trk.push_back(MARK_DATA);
		trk.push_back(8'h00);
		trk.push_back(8'h7F);
		send_track();

		for (int p = 0; p < 5; p++) begin
			settle();
			case (p)
				0, 4: tgt = 4'h0;
				1: tgt = 4'hF;
				default: tgt = 4'($urandom_range(1, 14));
			endcase
			write_target(tgt);
			while (sent < (p + 1) * PHASE_ITEMS)
				run_track();
		end
		settle();

		if (tracker.errors == 0)
			$display("gcr_sector_reader_core regression: pass");
		else
			$display("gcr_sector_reader_core regression: fail");
		$finish;
	end

endmodule

### filelist.f
design/gcr_pkg.sv
design/gcr_ctrl.sv
design/gcr_emit.sv
design/gcr_sector_reader_core.sv
tb/tb_gcr_sector_reader_core.sv
